// File: design/hbcs_pkg.sv
package hbcs_pkg;

	// Size of the configuration space
	localparam int SPACE_BYTES = 256;
	localparam int ADDR_W      = $clog2(SPACE_BYTES);

	// Request kinds
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// The one function that exists
	localparam logic [2:0] FUNC_PRESENT = 3'd0;

	// Bytes with special write behaviour
	localparam logic [7:0] ADDR_STATUS_HI = 8'h07;
	localparam logic [7:0] ADDR_LATENCY   = 8'h0d;
	localparam logic [7:0] ADDR_APBASE_LO = 8'h12;
	localparam logic [7:0] ADDR_APBASE_HI = 8'h13;
	localparam logic [7:0] ADDR_DRAM_CTL  = 8'h75;
	localparam logic [7:0] ADDR_MISC_7B   = 8'h7b;
	localparam logic [7:0] ADDR_AP_SIZE   = 8'h84;
	localparam logic [7:0] ADDR_GART_CTL  = 8'h88;
	localparam logic [7:0] ADDR_GART_BASE = 8'h89;
	localparam logic [7:0] ADDR_GART_B2   = 8'h8a;
	localparam logic [7:0] ADDR_GART_B3   = 8'h8b;

	localparam logic [7:0] STATUS_W1C  = 8'hb0;
	localparam logic [7:0] UPPER_NIB   = 8'hf0;
	localparam logic [7:0] LAT_SEL     = 8'h06;
	localparam logic [7:0] DRAM_KEEP   = 8'hcf;
	localparam logic [7:0] ABSENT_READ = 8'hff;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} hbcs_cmd_t;

	// Contents after reset
	function automatic logic [7:0] reset_image(input logic [7:0] a);
		logic [7:0] v;
		v = 8'h00;
		case (a) inside
			8'h00: v = 8'h06;
			8'h01: v = 8'h11;
			8'h02: v = 8'h91;
			8'h03: v = 8'h03;
			8'h04: v = 8'h06;
			8'h06: v = 8'h10;
			8'h07: v = 8'h02;
			8'h08: v = 8'hc2;
			8'h0b: v = 8'h06;
			8'h10: v = 8'h08;
			8'h34: v = 8'ha0;
			8'h52: v = 8'h70;
			8'h56, 8'h57: v = 8'h01;
			8'h58: v = 8'h40;
			[8'h5a:8'h5f]: v = 8'h01;
			[8'h64:8'h67]: v = 8'hec;
			8'h68, 8'h6b: v = 8'h01;
			8'ha0: v = 8'h02;
			8'ha2: v = 8'h20;
			8'ha4: v = 8'h03;
			8'ha5: v = 8'h02;
			8'ha7: v = 8'h1f;
			8'had: v = 8'h02;
			8'hb0: v = 8'h80;
			8'hb1: v = 8'h63;
			8'hc0: v = 8'h01;
			8'hc2: v = 8'h02;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// Bytes that ignore writes
	function automatic logic is_read_only(input logic [7:0] a);
		logic r;
		r = 1'b0;
		case (a) inside
			[8'h00:8'h03], 8'h06, [8'h08:8'h0c], [8'h0e:8'h11], [8'h14:8'h2b],
			[8'h30:8'h4f], 8'h6f, [8'h7c:8'h7d], [8'h81:8'h83], [8'h85:8'h87],
			[8'h8c:8'ha7], [8'haa:8'hab], 8'haf, [8'hb3:8'hc3], [8'hc5:8'hdf],
			[8'he1:8'hef], [8'hf9:8'hfb]: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Writable bits of merged registers; full byte elsewhere
	function automatic logic [7:0] merge_mask(input logic [7:0] a);
		logic [7:0] m;
		m = 8'hff;
		case (a)
			8'h04: m = 8'h40;
			8'h0d: m = 8'hf8;
			8'h68: m = 8'hfc;
			8'h69: m = 8'hfe;
			8'h6c: m = 8'h1f;
			8'h6e: m = 8'hbf;
			8'h70: m = 8'hdf;
			8'h71: m = 8'hdf;
			8'h73: m = 8'h7f;
			8'h74: m = 8'hdf;
			8'h75: m = 8'hcf;
			8'h78: m = 8'hd5;
			8'h79: m = 8'hfc;
			8'h7a: m = 8'h99;
			8'h7e: m = 8'h3f;
			8'h80: m = 8'h8f;
			8'h88: m = 8'h06;
			8'ha8: m = 8'h37;
			8'ha9: m = 8'h03;
			8'hac: m = 8'h7f;
			8'had: m = 8'h1f;
			8'hae: m = 8'h34;
			8'hb0: m = 8'hc0;
			8'hb2: m = 8'h93;
			8'hc4: m = 8'h03;
			8'he0: m = 8'h01;
			8'hfd: m = 8'h1f;
			default: m = 8'hff;
		endcase
		return m;
	endfunction

endpackage

// File: design/hbcs_ctrl.sv
module hbcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output hbcs_pkg::hbcs_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic accept;

	// Take an item when idle and the result slot is free or draining
	assign s_tready    = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept      = s_tvalid && s_tready;
	assign m_tvalid    = out_valid_q;
	assign cmd.capture = accept;
	assign cmd.execute = (state_q == ST_EXEC);

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EXEC) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: design/hbcs_dpath.sv
module hbcs_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  hbcs_pkg::hbcs_cmd_t cmd,
	input  logic                in_req_type,
	input  logic [2:0]          in_function_number,
	input  logic [7:0]          in_reg_addr,
	input  logic [7:0]          in_write_data,
	output logic [7:0]          read_data
);

	logic [7:0] mem_q [hbcs_pkg::SPACE_BYTES];
	logic [hbcs_pkg::SPACE_BYTES-1:0] vld_q;

	logic [7:0] mem_rd_s1;
	logic       vld_s1;
	logic [7:0] img_s1;
	logic       req_type_s1;
	logic [2:0] func_s1;
	logic [7:0] addr_s1;
	logic [7:0] wdata_s1;

	logic [7:0] ap_lo_q, ap_hi_q, dram_q, ap_size_q;
	logic [7:0] read_data_q;

	logic [7:0] cur;
	logic [7:0] new_byte;
	logic [7:0] mask;
	logic       do_write;
	logic       is_reg;
	logic       realign;
	logic [7:0] size_v;
	logic [7:0] n_ap_lo, n_ap_hi, n_dram, n_ap_size;

	// Capture the request and read the addressed byte
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mem_rd_s1   <= mem_q[in_reg_addr];
			vld_s1      <= vld_q[in_reg_addr];
			img_s1      <= hbcs_pkg::reset_image(in_reg_addr);
			req_type_s1 <= in_req_type;
			func_s1     <= in_function_number;
			addr_s1     <= in_reg_addr;
			wdata_s1    <= in_write_data;
		end
		if (cmd.execute && do_write && !is_reg) begin
			mem_q[addr_s1] <= new_byte;
		end
	end

	// Mark written entries; unwritten ones read as the reset image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.execute && do_write && !is_reg) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	// Compute the new byte and its side effects
	always_comb begin
		is_reg = (addr_s1 == hbcs_pkg::ADDR_APBASE_LO) || (addr_s1 == hbcs_pkg::ADDR_APBASE_HI) ||
			(addr_s1 == hbcs_pkg::ADDR_DRAM_CTL) || (addr_s1 == hbcs_pkg::ADDR_AP_SIZE);
		case (addr_s1)
			hbcs_pkg::ADDR_APBASE_LO: cur = ap_lo_q;
			hbcs_pkg::ADDR_APBASE_HI: cur = ap_hi_q;
			hbcs_pkg::ADDR_DRAM_CTL:  cur = dram_q;
			hbcs_pkg::ADDR_AP_SIZE:   cur = ap_size_q;
			default:                  cur = vld_s1 ? mem_rd_s1 : img_s1;
		endcase

		do_write = (req_type_s1 == hbcs_pkg::REQ_WRITE) &&
			(func_s1 == hbcs_pkg::FUNC_PRESENT) && !hbcs_pkg::is_read_only(addr_s1);

		mask = hbcs_pkg::merge_mask(addr_s1);
		case (addr_s1)
			hbcs_pkg::ADDR_STATUS_HI: new_byte = cur & ~(wdata_s1 & hbcs_pkg::STATUS_W1C);
			hbcs_pkg::ADDR_APBASE_LO: new_byte = wdata_s1 & hbcs_pkg::UPPER_NIB;
			hbcs_pkg::ADDR_MISC_7B:   new_byte = wdata_s1 & 8'h01;
			hbcs_pkg::ADDR_GART_BASE: new_byte = wdata_s1 & hbcs_pkg::UPPER_NIB;
			default:                  new_byte = (cur & ~mask) | (wdata_s1 & mask);
		endcase

		realign = (addr_s1 == hbcs_pkg::ADDR_APBASE_LO) || (addr_s1 == hbcs_pkg::ADDR_APBASE_HI) ||
			(addr_s1 == hbcs_pkg::ADDR_AP_SIZE) || (addr_s1 == hbcs_pkg::ADDR_GART_CTL) ||
			(addr_s1 == hbcs_pkg::ADDR_GART_BASE) || (addr_s1 == hbcs_pkg::ADDR_GART_B2) ||
			(addr_s1 == hbcs_pkg::ADDR_GART_B3);

		n_ap_lo   = (addr_s1 == hbcs_pkg::ADDR_APBASE_LO) ? new_byte : ap_lo_q;
		n_ap_hi   = (addr_s1 == hbcs_pkg::ADDR_APBASE_HI) ? new_byte : ap_hi_q;
		n_ap_size = (addr_s1 == hbcs_pkg::ADDR_AP_SIZE)   ? new_byte : ap_size_q;
		n_dram    = (addr_s1 == hbcs_pkg::ADDR_DRAM_CTL)  ? new_byte : dram_q;

		// Latency byte also drives bits 5:4 of the DRAM control byte
		if (addr_s1 == hbcs_pkg::ADDR_LATENCY) begin
			n_dram = (dram_q & hbcs_pkg::DRAM_KEEP) | ((wdata_s1 & hbcs_pkg::LAT_SEL) << 3);
		end

		// Align the aperture base to the aperture size
		size_v = n_ap_size;
		if (realign) begin
			n_ap_lo = n_ap_lo & {size_v[3:0], 4'h0};
			n_ap_hi = n_ap_hi & (hbcs_pkg::UPPER_NIB | {4'h0, size_v[7:4]});
		end
	end

	// Update the register-held bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_lo_q   <= hbcs_pkg::reset_image(hbcs_pkg::ADDR_APBASE_LO);
			ap_hi_q   <= hbcs_pkg::reset_image(hbcs_pkg::ADDR_APBASE_HI);
			dram_q    <= hbcs_pkg::reset_image(hbcs_pkg::ADDR_DRAM_CTL);
			ap_size_q <= hbcs_pkg::reset_image(hbcs_pkg::ADDR_AP_SIZE);
		end else if (cmd.execute && do_write) begin
			ap_lo_q   <= n_ap_lo;
			ap_hi_q   <= n_ap_hi;
			dram_q    <= n_dram;
			ap_size_q <= n_ap_size;
		end
	end

	// Load the result
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (req_type_s1 == hbcs_pkg::REQ_WRITE) begin
				read_data_q <= 8'h00;
			end else if (func_s1 != hbcs_pkg::FUNC_PRESENT) begin
				read_data_q <= hbcs_pkg::ABSENT_READ;
			end else begin
				read_data_q <= cur;
			end
		end
	end

	assign read_data = read_data_q;

endmodule

// File: design/host_bridge_config_space.sv
// Host bridge configuration space: 256 bytes, one byte access per item.
// Input channel s_*: tdata carries req_type, function_number, reg_addr and
// write_data. Output channel m_*: tdata carries read_data, one item for
// every input item, in order.
// Reads of function 0 return the stored byte, other functions read 0xff,
// and every write returns 0. Writes follow per-byte masks, clear-on-one
// status bits and the aperture and latency side effects.
// Result: the request is captured, then the execute state loads the result
// register, which holds it until m_tready takes it.
// Throughput: no new item is taken during the registered memory read and
// the read-modify-write step that follow it; the next item can be taken
// in the same cycle as the previous result is taken.
// Reset: asynchronous, active low. Contents return to the setup image at
// once, through per-byte valid bits; no clearing pass is needed.
// Stall: while the result waits on m_tready no new item is taken; s_tready
// returns in the cycle the result is taken.
module host_bridge_config_space (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // req_type[0], function_number[3:1], reg_addr[11:4],
	                              // write_data[19:12], zero[23:20]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // read_data[7:0]
);

	hbcs_pkg::hbcs_cmd_t cmd;

	hbcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	hbcs_dpath u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.in_req_type        (s_tdata[0]),
		.in_function_number (s_tdata[3:1]),
		.in_reg_addr        (s_tdata[11:4]),
		.in_write_data      (s_tdata[19:12]),
		.read_data          (m_tdata)
	);

	// Not ready in the cycle after an item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item taken while busy");

	// Result appears after the capture and execute registers once an item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##2 m_tvalid)
		else $error("result missing after item");

	// Writes always return zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tdata[0] == hbcs_pkg::REQ_WRITE)) |-> ##2
		(m_tdata == 8'h00))
		else $error("write returned non-zero data");

endmodule
